>>> src/current_moving_average_calibrate_macros.svh
// assertion macros shared by the current filter modules
// expects clk_i and rst_ni in the scope of each use
`ifndef CURRENT_MOVING_AVERAGE_CALIBRATE_MACROS_SVH
`define CURRENT_MOVING_AVERAGE_CALIBRATE_MACROS_SVH

// property checked on every rising clock edge outside reset
`define CMAC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define CMAC_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

>>> src/cmac_pkg.sv
// shared constants and the trim clamp of the current moving average filter
// no dependencies
`timescale 1ns / 1ps

package cmac_pkg;

  localparam int OPD_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int TRIM_W     = 11;
  localparam int SCALE_W    = 8;

  localparam int ADC_COEF = 19966;
  localparam int CAL_DIV  = 1000;

  localparam logic signed [TRIM_W-1:0] TRIM_MAX = 11'sd1000;
  localparam logic signed [TRIM_W-1:0] TRIM_MIN = -11'sd1000;

  localparam logic [CFG_IDX_W-1:0] REG_SENSOR_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_TRIM    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_TRIM    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_SCALE = 3'd3;

  function automatic logic signed [TRIM_W-1:0] clamp_trim(logic signed [TRIM_W-1:0] v);
    logic signed [TRIM_W-1:0] r;
    r = v;
    if (v > TRIM_MAX) begin
      r = TRIM_MAX;
    end else if (v < TRIM_MIN) begin
      r = TRIM_MIN;
    end
    return r;
  endfunction

endpackage

>>> src/cmac_ring.sv
// sample ring with running sum, one read and one write slot per beat
// depends on current_moving_average_calibrate_macros.svh
`timescale 1ns / 1ps
`include "current_moving_average_calibrate_macros.svh"

module cmac_ring #(
  parameter int WINDOW_LEN  = 12,
  parameter int SAMPLE_BITS = 20,
  parameter int SUM_W       = SAMPLE_BITS + $clog2(WINDOW_LEN)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  output logic                          done_o,
  output logic signed [SUM_W-1:0]       sum_o
);

  localparam int PTR_W = $clog2(WINDOW_LEN);
  localparam logic [PTR_W-1:0] LAST_POS = PTR_W'(WINDOW_LEN - 1);

  logic [SAMPLE_BITS-1:0]        mem [WINDOW_LEN];
  logic [SAMPLE_BITS-1:0]        rd_q;
  logic signed [SAMPLE_BITS-1:0] smp_q;
  logic [WINDOW_LEN-1:0]         vld_q;
  logic                          old_vld_q;
  logic                          pend_q;
  logic                          done_q;
  logic [PTR_W-1:0]              pos_q;
  logic signed [SUM_W-1:0]       sum_q;
  logic signed [SUM_W-1:0]       old_val;

  assign old_val = old_vld_q ? SUM_W'($signed(rd_q)) : '0;

  always_ff @(posedge clk_i) begin
    if (pend_q) begin
      mem[pos_q] <= smp_q;
    end
    if (push_i) begin
      rd_q  <= mem[pos_q];
      smp_q <= sample_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      old_vld_q <= 1'b0;
      pend_q    <= 1'b0;
      done_q    <= 1'b0;
      pos_q     <= '0;
      sum_q     <= '0;
    end else begin
      pend_q <= push_i;
      done_q <= pend_q;
      if (push_i) begin
        old_vld_q <= vld_q[pos_q];
      end
      if (pend_q) begin
        sum_q        <= sum_q - old_val + SUM_W'(smp_q);
        vld_q[pos_q] <= 1'b1;
        pos_q        <= (pos_q == LAST_POS) ? '0 : pos_q + 1'b1;
      end
    end
  end

  assign done_o = done_q;
  assign sum_o  = sum_q;

  `CMAC_NEVER(a_push_overlap, push_i && (pend_q || done_q), "ring push while update pending")
  `CMAC_ASSERT(a_done_follows, done_q |-> $past(pend_q), "ring done without update")

endmodule

>>> src/cmac_alu.sv
// shared shift-add multiplier on magnitudes, one bit of the second operand per cycle
// depends on current_moving_average_calibrate_macros.svh
`timescale 1ns / 1ps
`include "current_moving_average_calibrate_macros.svh"

module cmac_alu #(
  parameter int A_W = 36,
  parameter int B_W = 37
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [A_W-1:0]     opd_a_i,
  input  logic [B_W-1:0]     opd_b_i,
  output logic               done_o,
  output logic [A_W+B_W-1:0] result_o
);

  localparam int P_W = A_W + B_W;

  logic           busy_q;
  logic           done_q;
  logic [P_W-1:0] acc_q;
  logic [P_W-1:0] a_q;
  logic [B_W-1:0] b_q;
  logic           finish;

  assign finish = (b_q == '0);

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      a_q   <= P_W'(opd_a_i);
      b_q   <= opd_b_i;
    end else if (busy_q && !finish) begin
      if (b_q[0]) begin
        acc_q <= acc_q + a_q;
      end
      a_q <= {a_q[P_W-2:0], 1'b0};
      b_q <= {1'b0, b_q[B_W-1:1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && finish) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  assign done_o   = done_q;
  assign result_o = acc_q;

  `CMAC_NEVER(a_start_busy, start_i && (busy_q || done_q), "alu start while busy")
  `CMAC_ASSERT(a_done_pulse, done_q |=> !done_q, "alu done longer than one cycle")

endmodule

>>> src/current_moving_average_calibrate.sv
// Moving-average current filter with linear ADC calibration. Each accepted sample
// goes into a WINDOW_LEN ring (zero after reset) and the running sum is divided by
// WINDOW_LEN, truncated toward zero. With sensor_mode 0 the mean gets zero_trim added,
// is multiplied by (19966 + gain_trim) and divided by 1000; then it is multiplied by
// output_scale and saturated to 32 bits. Multiplies and divisions run on one shared
// shift-add multiplier that retires one bit of its second operand per cycle; both
// divisions are multiplies by a rounded-up reciprocal followed by a fixed right shift.
// A sample is taken, the ring is updated, then each multiply runs in turn (the second
// operand is SUM_W + 1 bits for the window reciprocal, 15 for the coefficient, MAG_W + 1
// for the reciprocal of 1000, up to 8 for |output_scale|), with the zero trim before the
// coefficient multiply in ADC mode and saturation last, where SUM_W = SAMPLE_BITS +
// clog2(WINDOW_LEN) and MAG_W = max(SAMPLE_BITS, 17) + 16. Each multiply stops at the
// top set bit of its second operand. The input is not ready from an accept until the
// result is loaded into the output register; a finished result is held in the output
// register while the next sample may be taken, and a result that is still held stalls
// the block.
// Depends on cmac_pkg, cmac_ring, cmac_alu and the macros header.
`timescale 1ns / 1ps
`include "current_moving_average_calibrate_macros.svh"

module current_moving_average_calibrate #(
  parameter int WINDOW_LEN  = 12,
  parameter int SAMPLE_BITS = 20
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0]       sample_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [31:0]                  current_ma_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [cmac_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [cmac_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int SUM_W   = SAMPLE_BITS + $clog2(WINDOW_LEN);
  localparam int MAG_W   = ((SAMPLE_BITS > 17) ? SAMPLE_BITS : 17) + 16;
  localparam int VAL_W   = MAG_W + 1;
  localparam int P_W     = MAG_W + VAL_W;
  localparam int OPD_W   = cmac_pkg::OPD_W;
  localparam int MEAN_SH = SUM_W + $clog2(WINDOW_LEN);
  localparam int CAL_SH  = MAG_W + $clog2(cmac_pkg::CAL_DIV);
  // rounded-up reciprocals, exact for dividends below 2**SUM_W and 2**MAG_W
  localparam longint unsigned MEAN_RCP =
    ((64'd1 << MEAN_SH) + 64'(WINDOW_LEN - 1)) / 64'(WINDOW_LEN);
  localparam longint unsigned CAL_RCP =
    ((64'd1 << CAL_SH) + 64'(cmac_pkg::CAL_DIV - 1)) / 64'(cmac_pkg::CAL_DIV);
  localparam logic signed [VAL_W-1:0] SAT_HI = VAL_W'(64'sd2147483647);
  localparam logic signed [VAL_W-1:0] SAT_LO = VAL_W'(-64'sd2147483648);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_RING  = 8'b0000_0010,
    S_MEAN  = 8'b0000_0100,
    S_TRIM  = 8'b0000_1000,
    S_CALM  = 8'b0001_0000,
    S_CALD  = 8'b0010_0000,
    S_SCALE = 8'b0100_0000,
    S_SAT   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   go_q, go_d;
  logic   neg_q, neg_d;
  logic signed [VAL_W-1:0] val_q, val_d;

  logic                                  mode_q;
  logic signed [cmac_pkg::TRIM_W-1:0]    gain_q;
  logic signed [cmac_pkg::TRIM_W-1:0]    zero_q;
  logic signed [cmac_pkg::SCALE_W-1:0]   scale_q;

  logic                    out_valid_q, out_valid_d;
  logic signed [31:0]      out_data_q;
  logic                    out_load;

  logic                    in_fire;
  logic                    ring_done;
  logic signed [SUM_W-1:0] ring_sum;
  logic                    alu_start;
  logic [VAL_W-1:0]        alu_b;
  logic                    alu_done;
  logic [P_W-1:0]          alu_res;
  logic [MAG_W-1:0]        res_mag;
  logic signed [VAL_W-1:0] val_abs;
  logic signed [VAL_W-1:0] res_ext;
  logic signed [OPD_W-1:0] coef;
  logic [cmac_pkg::SCALE_W-1:0] scale_mag;
  logic signed [31:0]      sat_val;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  assign val_abs   = val_q[VAL_W-1] ? -val_q : val_q;
  assign res_ext   = $signed({1'b0, res_mag});
  assign coef      = OPD_W'(cmac_pkg::ADC_COEF) + OPD_W'(gain_q);
  assign scale_mag = scale_q[cmac_pkg::SCALE_W-1] ? -scale_q : scale_q;

  cmac_ring #(
    .WINDOW_LEN (WINDOW_LEN),
    .SAMPLE_BITS(SAMPLE_BITS),
    .SUM_W      (SUM_W)
  ) u_ring (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_fire),
    .sample_i(sample_i),
    .done_o  (ring_done),
    .sum_o   (ring_sum)
  );

  cmac_alu #(
    .A_W(MAG_W),
    .B_W(VAL_W)
  ) u_alu (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (alu_start),
    .opd_a_i (val_abs[MAG_W-1:0]),
    .opd_b_i (alu_b),
    .done_o  (alu_done),
    .result_o(alu_res)
  );

  always_comb begin
    alu_start = go_q;
    alu_b     = '0;
    unique case (state_q)
      S_MEAN: begin
        alu_b = VAL_W'(MEAN_RCP);
      end
      S_CALM: begin
        alu_b = VAL_W'($unsigned(coef));
      end
      S_CALD: begin
        alu_b = VAL_W'(CAL_RCP);
      end
      S_SCALE: begin
        alu_b = VAL_W'(scale_mag);
      end
      default: begin
        alu_start = 1'b0;
      end
    endcase
  end

  // quotients sit above the reciprocal shift, plain products at the bottom
  always_comb begin
    unique case (state_q)
      S_MEAN: begin
        res_mag = alu_res[MEAN_SH +: MAG_W];
      end
      S_CALD: begin
        res_mag = MAG_W'(alu_res[P_W-1:CAL_SH]);
      end
      default: begin
        res_mag = alu_res[MAG_W-1:0];
      end
    endcase
  end

  always_comb begin
    if (val_q > SAT_HI) begin
      sat_val = 32'sh7fff_ffff;
    end else if (val_q < SAT_LO) begin
      sat_val = 32'sh8000_0000;
    end else begin
      sat_val = val_q[31:0];
    end
  end

  assign out_load    = (state_q == S_SAT) && (!out_valid_q || out_ready_i);
  assign out_valid_d = out_load || (out_valid_q && !out_ready_i);

  always_comb begin
    state_d = state_q;
    go_d    = 1'b0;
    neg_d   = neg_q;
    val_d   = val_q;
    if (go_q) begin
      neg_d = val_q[VAL_W-1];
      if (state_q == S_SCALE) begin
        neg_d = val_q[VAL_W-1] ^ scale_q[cmac_pkg::SCALE_W-1];
      end
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = S_RING;
        end
      end
      S_RING: begin
        if (ring_done) begin
          val_d   = VAL_W'(ring_sum);
          go_d    = 1'b1;
          state_d = S_MEAN;
        end
      end
      S_MEAN: begin
        if (alu_done) begin
          val_d = neg_q ? -res_ext : res_ext;
          if (mode_q) begin
            go_d    = 1'b1;
            state_d = S_SCALE;
          end else begin
            state_d = S_TRIM;
          end
        end
      end
      S_TRIM: begin
        val_d   = val_q + VAL_W'(zero_q);
        go_d    = 1'b1;
        state_d = S_CALM;
      end
      S_CALM: begin
        if (alu_done) begin
          val_d   = neg_q ? -res_ext : res_ext;
          go_d    = 1'b1;
          state_d = S_CALD;
        end
      end
      S_CALD: begin
        if (alu_done) begin
          val_d   = neg_q ? -res_ext : res_ext;
          go_d    = 1'b1;
          state_d = S_SCALE;
        end
      end
      S_SCALE: begin
        if (alu_done) begin
          val_d   = neg_q ? -res_ext : res_ext;
          state_d = S_SAT;
        end
      end
      S_SAT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    neg_q <= neg_d;
    if (out_load) begin
      out_data_q <= sat_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      go_q        <= 1'b0;
      out_valid_q <= 1'b0;
      mode_q      <= 1'b1;
      gain_q      <= '0;
      zero_q      <= '0;
      scale_q     <= 8'sd1;
    end else begin
      state_q     <= state_d;
      go_q        <= go_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          cmac_pkg::REG_SENSOR_MODE: begin
            mode_q <= cfg_data_i[0];
          end
          cmac_pkg::REG_GAIN_TRIM: begin
            gain_q <= cmac_pkg::clamp_trim(cfg_data_i[cmac_pkg::TRIM_W-1:0]);
          end
          cmac_pkg::REG_ZERO_TRIM: begin
            zero_q <= cmac_pkg::clamp_trim(cfg_data_i[cmac_pkg::TRIM_W-1:0]);
          end
          cmac_pkg::REG_OUTPUT_SCALE: begin
            scale_q <= cfg_data_i[cmac_pkg::SCALE_W-1:0];
          end
          default: begin
            mode_q <= mode_q;
          end
        endcase
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign current_ma_o = out_data_q;

  `CMAC_ASSERT(a_alu_done_state, alu_done |-> (state_q == S_MEAN || state_q == S_CALM ||
               state_q == S_CALD || state_q == S_SCALE), "alu done outside a wait state")
  `CMAC_ASSERT(a_ring_done_state, ring_done |-> state_q == S_RING, "ring done outside ring state")

endmodule
